// ===== src/ccp_pkg.sv =====
// Package for the compaction copy planner: sizing constants, beat payload
// structs, table entry type and sequencer state codes. No dependencies.
package ccp_pkg;

    localparam int MAX_CHUNKS  = 256;
    localparam int OFFSET_BITS = 40;
    localparam int IDX_BITS    = $clog2(MAX_CHUNKS);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int ENTRY_BITS  = 2 * OFFSET_BITS;

    typedef logic [OFFSET_BITS-1:0] t_ofs;
    typedef logic [OFFSET_BITS:0]   t_ofs_cy;

    typedef struct packed {
        t_ofs chunk_size;
        t_ofs chunk_offset;
        logic last_chunk;
    } t_in_item;

    typedef struct packed {
        logic staged;
        t_ofs copy_size;
        t_ofs source_offset;
        t_ofs dest_offset;
        t_ofs stage_offset;
        t_ofs stage_total;
        logic table_full;
        logic run_end;
    } t_out_item;

    typedef struct packed {
        t_ofs offset;
        t_ofs size;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

endpackage

// ===== src/ccp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; sized by its parameters.
module ccp_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ccp_cmp.sv =====
// Shared overlap compare: tests one stored direct chunk against the
// destination range of the current chunk. Depends on ccp_pkg.
module ccp_cmp (
    input  ccp_pkg::t_entry  i_entry,
    input  ccp_pkg::t_ofs    i_pre,
    input  ccp_pkg::t_ofs_cy i_dest_end,
    output logic             o_hit
);
    import ccp_pkg::*;

    t_ofs_cy src_end;

    // exact sums: the carry bit keeps an overflowing sum larger than any offset
    assign src_end = {1'b0, i_entry.offset} + {1'b0, i_entry.size};
    assign o_hit   = (src_end > {1'b0, i_pre}) && (i_dest_end > {1'b0, i_entry.offset});

endmodule

// ===== src/compaction_copy_planner.sv =====
// Top level of the compaction copy planner: sequencer, running totals,
// direct-chunk table (ccp_ram) and shared compare (ccp_cmp). Uses ccp_pkg.
//
// Chunks of one run arrive in offset order, one per input beat, and are
// packed toward offset zero. Each beat yields exactly one result beat with
// the route (direct or through staging), the source, destination and staging
// offsets and the staging total so far. A chunk whose destination range
// reaches its own source, or overlaps the source of an earlier directly
// copied chunk, is staged; the search stops at the first overlap. Directly
// copied chunks are recorded in a table of MAX_CHUNKS entries; once it is
// full further chunks are staged with table_full set. A beat with
// last_chunk set closes the run and clears all running state. The number of
// table entries searched runs from none up to the number of direct chunks
// so far in the run, at most MAX_CHUNKS - 1, as a full table skips the
// search; the single compare unit checks one entry per cycle as entries
// stream from the table read port. A finished result waits while the output
// still holds an earlier result that has not been taken. The input stall is
// high whenever a chunk is being worked on; no clearing pass is needed after
// reset.
module compaction_copy_planner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ccp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ccp_pkg::t_out_item o_out_data
);
    import ccp_pkg::*;

    t_state               r_state, n_state;
    t_in_item             r_item, n_item;
    t_ofs_cy              r_dest_end, n_dest_end;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic                 r_staged, n_staged;
    logic                 r_full, n_full;
    t_ofs                 r_compacted, n_compacted;
    t_ofs                 r_stage_end, n_stage_end;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data, n_out_data;

    logic [CNT_BITS-1:0]  idx_next;
    logic                 rd_en;
    logic [IDX_BITS-1:0]  rd_addr;
    logic [ENTRY_BITS-1:0] rd_data;
    logic                 wr_en;
    t_entry               wr_entry;
    logic                 hit;
    logic                 out_free;
    t_ofs                 stage_after;

    assign idx_next = {1'b0, r_idx} + CNT_BITS'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    // table read: entry 0 issued while checking, then one ahead of the compare
    assign rd_en   = (r_state == ST_CHECK) || (r_state == ST_SEARCH);
    assign rd_addr = (r_state == ST_SEARCH) ? idx_next[IDX_BITS-1:0] : '0;

    // record a direct chunk when its result leaves
    assign wr_en    = (r_state == ST_DONE) && out_free && !r_staged;
    assign wr_entry = '{offset: r_item.chunk_offset, size: r_item.chunk_size};

    assign stage_after = r_staged ? (r_stage_end + r_item.chunk_size) : r_stage_end;

    ccp_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_CHUNKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_BITS-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ccp_cmp u_cmp (
        .i_entry    (t_entry'(rd_data)),
        .i_pre      (r_compacted),
        .i_dest_end (r_dest_end),
        .o_hit      (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_dest_end  = r_dest_end;
        n_idx       = r_idx;
        n_staged    = r_staged;
        n_full      = r_full;
        n_compacted = r_compacted;
        n_stage_end = r_stage_end;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // drop the held result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item     = i_in_data;
                    n_dest_end = {1'b0, r_compacted} + {1'b0, i_in_data.chunk_size};
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_staged = 1'b0;
                n_full   = 1'b0;
                n_idx    = '0;
                if (r_dest_end >= {1'b0, r_item.chunk_offset}) begin
                    // destination reaches its own source
                    n_staged = 1'b1;
                    n_state  = ST_DONE;
                end else if (r_count == CNT_BITS'(MAX_CHUNKS)) begin
                    n_staged = 1'b1;
                    n_full   = 1'b1;
                    n_state  = ST_DONE;
                end else if (r_count == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    // stop at the first overlap
                    n_staged = 1'b1;
                    n_state  = ST_DONE;
                end else if (idx_next == r_count) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = idx_next[IDX_BITS-1:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{
                        staged:        r_staged,
                        copy_size:     r_item.chunk_size,
                        source_offset: r_item.chunk_offset,
                        dest_offset:   r_compacted,
                        stage_offset:  r_staged ? r_stage_end : '0,
                        stage_total:   stage_after,
                        table_full:    r_full,
                        run_end:       r_item.last_chunk
                    };
                    n_stage_end = stage_after;
                    n_compacted = r_compacted + r_item.chunk_size;
                    if (!r_staged) begin
                        n_count = r_count + CNT_BITS'(1);
                    end
                    // close the run
                    if (r_item.last_chunk) begin
                        n_stage_end = '0;
                        n_compacted = '0;
                        n_count     = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_compacted <= '0;
            r_stage_end <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_staged    <= 1'b0;
            r_full      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_compacted <= n_compacted;
            r_stage_end <= n_stage_end;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_staged    <= n_staged;
            r_full      <= n_full;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_dest_end <= n_dest_end;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_CHUNKS))
        else $error("direct table count beyond capacity");

    a_full_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.table_full |-> r_out_data.staged)
        else $error("table_full result not staged");

    a_direct_no_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.staged |-> r_out_data.stage_offset == '0)
        else $error("direct result carries a staging offset");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && out_free && r_item.last_chunk |=>
            (r_count == '0) && (r_compacted == '0) && (r_stage_end == '0))
        else $error("running state not cleared after run end");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> ({1'b0, r_idx} < r_count))
        else $error("search beyond recorded entries");
`endif

endmodule

// ===== tb/tb_compaction_copy_planner.sv =====
// Self-checking bench for compaction_copy_planner: drives chunk beats, plans
// each copy in a local model and checks every result beat field by field.
// Depends on ccp_pkg and the compaction_copy_planner RTL only.
`timescale 1ns / 1ps

module tb_compaction_copy_planner;

    import ccp_pkg::*;

    // Longest stretch with no beat on either side: the receiver hold-off plus
    // a full table search, taken many times over.
    localparam int QUIET_LIMIT = 5000;
    // Cycles to wait after the last result: one chunk with a full search.
    localparam int TAIL_CYCLES = MAX_CHUNKS + 40;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;
    localparam t_ofs OFS_ALL   = {OFFSET_BITS{1'b1}};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    compaction_copy_planner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Chunks waiting to be offered, and copy plans waiting for their result.
    t_in_item  chunks_to_send[$];
    t_out_item planned_copies[$];

    // Local copy of the planner state.
    t_ofs   packed_end;
    t_ofs   staging_end;
    t_entry direct_table[MAX_CHUNKS];
    int     direct_n;

    int chunks_total;
    int chunks_in;
    int copies_out;
    int staged_seen;
    int full_seen;
    int runs_seen;
    int mismatches;
    int quiet_cycles;
    logic in_taken = 1'b0;

    function automatic t_ofs rand_ofs();
        return t_ofs'({$urandom, $urandom});
    endfunction

    // Plan one chunk: route, offsets and staging total; advance the running
    // state, and clear it at the end of a run.
    function automatic t_out_item plan_chunk(t_in_item chunk);
        t_out_item plan;
        logic      hit;
        int        k;
        plan = '0;
        hit  = 1'b0;
        if (t_ofs_cy'(packed_end) + t_ofs_cy'(chunk.chunk_size) >=
            t_ofs_cy'(chunk.chunk_offset)) begin
            // destination reaches the chunk's own source
            hit = 1'b1;
        end else if (direct_n >= MAX_CHUNKS) begin
            hit = 1'b1;
            plan.table_full = 1'b1;
        end else begin
            // stop at the first earlier direct source that the new place hits
            for (k = 0; k < direct_n && !hit; k++) begin
                if (t_ofs_cy'(packed_end) <
                        t_ofs_cy'(direct_table[k].offset) + t_ofs_cy'(direct_table[k].size) &&
                    t_ofs_cy'(packed_end) + t_ofs_cy'(chunk.chunk_size) >
                        t_ofs_cy'(direct_table[k].offset))
                    hit = 1'b1;
            end
        end
        plan.staged        = hit;
        plan.copy_size     = chunk.chunk_size;
        plan.source_offset = chunk.chunk_offset;
        plan.dest_offset   = packed_end;
        plan.run_end       = chunk.last_chunk;
        if (hit) begin
            plan.stage_offset = staging_end;
            staging_end       = staging_end + chunk.chunk_size;
        end else begin
            direct_table[direct_n].offset = chunk.chunk_offset;
            direct_table[direct_n].size   = chunk.chunk_size;
            direct_n++;
        end
        plan.stage_total = staging_end;
        packed_end       = packed_end + chunk.chunk_size;
        if (chunk.last_chunk) begin
            packed_end  = '0;
            staging_end = '0;
            direct_n    = 0;
        end
        return plan;
    endfunction

    task automatic flag_mismatch(string what, t_ofs got, t_ofs want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch on result %0d: %s got %h want %h", copies_out, what, got, want);
        mismatches++;
    endtask

    task automatic check_copy(t_out_item got, t_out_item want);
        if (got.staged !== want.staged)
            flag_mismatch("staged", t_ofs'(got.staged), t_ofs'(want.staged));
        if (got.copy_size !== want.copy_size)
            flag_mismatch("copy_size", got.copy_size, want.copy_size);
        if (got.source_offset !== want.source_offset)
            flag_mismatch("source_offset", got.source_offset, want.source_offset);
        if (got.dest_offset !== want.dest_offset)
            flag_mismatch("dest_offset", got.dest_offset, want.dest_offset);
        if (got.stage_offset !== want.stage_offset)
            flag_mismatch("stage_offset", got.stage_offset, want.stage_offset);
        if (got.stage_total !== want.stage_total)
            flag_mismatch("stage_total", got.stage_total, want.stage_total);
        if (got.table_full !== want.table_full)
            flag_mismatch("table_full", t_ofs'(got.table_full), t_ofs'(want.table_full));
        if (got.run_end !== want.run_end)
            flag_mismatch("run_end", t_ofs'(got.run_end), t_ofs'(want.run_end));
    endtask

    task automatic add_chunk(t_ofs size, t_ofs offset, logic last);
        t_in_item chunk;
        chunk.chunk_size   = size;
        chunk.chunk_offset = offset;
        chunk.last_chunk   = last;
        chunks_to_send = {chunks_to_send, chunk};
    endtask

    // Queue a well-formed run: chunks in offset order with random gaps.
    task automatic add_run(int n, int unsigned max_size, int unsigned max_gap, t_ofs base);
        t_ofs at;
        t_ofs size;
        int   j;
        at = base;
        for (j = 0; j < n; j++) begin
            size = t_ofs'($urandom_range(0, max_size));
            at   = at + t_ofs'($urandom_range(0, max_gap));
            add_chunk(size, at, j == n - 1);
            at   = at + size;
        end
    endtask

    // Monitor: plan every accepted chunk, check every accepted result.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want           = plan_chunk(i_in_data);
                planned_copies = {planned_copies, want};
                chunks_in++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (planned_copies.size() == 0) begin
                    flag_mismatch("unexpected result, offset", o_out_data.source_offset, '0);
                end else begin
                    want = planned_copies.pop_front();
                    check_copy(o_out_data, want);
                end
                staged_seen += o_out_data.staged;
                full_seen   += o_out_data.table_full;
                runs_seen   += o_out_data.run_end;
                copies_out++;
            end
        end
    end

    // Driver: offer chunks in bursts with random gaps; hold a stalled beat.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (chunks_to_send.size() > 0) begin
                i_in_data  <= chunks_to_send.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in phases of varying density; once, hold off for a long
    // stretch so the block fills and stalls its input.
    int   hold_left   = 0;
    logic held_off    = 1'b0;
    int   phase_left  = 0;
    int   stall_style = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!held_off && copies_out >= 150) begin
            held_off    <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left  <= $urandom_range(16, 96);
                stall_style <= $urandom_range(0, 3);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_style)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_out_stall <= ($urandom_range(0, 1) == 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int   pick;
        int   n;
        int   j;
        logic long_run_done;
        packed_end    = '0;
        staging_end   = '0;
        direct_n      = 0;
        chunks_in     = 0;
        copies_out    = 0;
        staged_seen   = 0;
        full_seen     = 0;
        runs_seen     = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        long_run_done = 1'b0;

        // Empty chunk at offset zero: its place reaches its own source.
        add_chunk('0, '0, 1'b1);
        // Two direct chunks, then one overlapping both sources: stage it once
        // and stop the search; a later chunk reaching the second source is staged too.
        add_chunk(40'd4, 40'd10, 1'b0);
        add_chunk(40'd4, 40'd20, 1'b0);
        add_chunk(40'd15, 40'd40, 1'b0);
        add_chunk(40'd4, 40'd60, 1'b0);
        add_chunk('0, 40'd1000, 1'b1);
        // Carry out of the top bit in both overlap test and running totals.
        add_chunk(OFS_ALL, OFS_ALL, 1'b0);
        add_chunk(40'd5, OFS_ALL - 1, 1'b0);
        add_chunk('0, OFS_ALL, 1'b1);
        // Boundaries: equal sum stages, adjacent ranges stay direct.
        add_chunk('0, 40'd1, 1'b0);
        add_chunk(40'd1, 40'd1, 1'b0);
        add_chunk(OFS_ALL, '0, 1'b1);
        add_chunk(40'd1, 40'd2, 1'b0);
        add_chunk(40'd1, 40'd3, 1'b1);
        // Alternating bit patterns on both fields.
        add_chunk(40'h55_5555_5555, 40'haa_aaaa_aaaa, 1'b0);
        add_chunk(40'haa_aaaa_aaaa, 40'h55_5555_5555, 1'b1);

        while (chunks_to_send.size() < 660) begin
            if (!long_run_done && chunks_to_send.size() > 150) begin
                // Long run of small spaced chunks: fill the table, then
                // overflow it.
                add_run(MAX_CHUNKS + 20, 3, 16, t_ofs'($urandom_range(2000, 3000)));
                long_run_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                // noise: fully random fields
                add_chunk(rand_ofs(), rand_ofs(), $urandom_range(0, 3) == 0);
            end else if (pick == 2) begin
                // broken run: small chunks at random offsets
                n = $urandom_range(2, 6);
                for (j = 0; j < n; j++)
                    add_chunk(t_ofs'($urandom_range(0, 64)), rand_ofs(), j == n - 1);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        add_run($urandom_range(1, 16), 4, 16, t_ofs'($urandom_range(0, 256)));
                    end
                    1: begin
                        add_run($urandom_range(1, 16), 64, 0, t_ofs'($urandom_range(0, 256)));
                    end
                    default: begin
                        add_run($urandom_range(1, 16), 4096, 256, rand_ofs());
                    end
                endcase
            end
        end
        chunks_total = chunks_to_send.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (chunks_in < chunks_total || planned_copies.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("planned %0d chunks in %0d runs; %0d results, %0d staged, %0d table full",
                 chunks_in, runs_seen, copies_out, staged_seen, full_seen);
        if (mismatches == 0 && planned_copies.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/ccp_pkg.sv
src/ccp_ram.sv
src/ccp_cmp.sv
src/compaction_copy_planner.sv
tb/tb_compaction_copy_planner.sv
